### rtl/wsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsa_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int PERIOD_BITS = 16;
  localparam int SUM_BITS    = 48;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);

  typedef struct packed {
    logic                       start;
    logic signed [SUM_BITS-1:0] dividend;
    logic [PERIOD_BITS-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/wsa_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface wsa_in_if;
  import wsa_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;
  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface wsa_out_if;
  import wsa_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] average;
  logic                          is_seed;
  modport source (output valid, output average, output is_seed, input ready);
  modport sink   (input valid, input average, input is_seed, output ready);
endinterface

interface wsa_cfg_if;
  import wsa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [PERIOD_BITS-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/wsa_div.sv
`timescale 1ns / 1ps
`default_nettype none

module wsa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wsa_pkg::div_req_t req,
  output wsa_pkg::div_rsp_t rsp
);
  import wsa_pkg::*;

  localparam int CNT_BITS = $clog2(SUM_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(SUM_BITS - 1);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIX  = 3'b100
  } dstate_t;

  dstate_t                 state_r, state_nxt;
  logic [CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic                    neg_r, neg_nxt;
  logic [SUM_BITS-1:0]     quo_r, quo_nxt;
  logic [PERIOD_BITS-1:0]  rem_r, rem_nxt;
  logic [PERIOD_BITS-1:0]  dvs_r, dvs_nxt;

  logic [PERIOD_BITS:0]    rem_sh;
  logic [PERIOD_BITS:0]    diff;
  logic                    ge;

  // restoring step: one quotient bit per cycle on the magnitude
  assign rem_sh = {rem_r, quo_r[SUM_BITS-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = ~diff[PERIOD_BITS];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    neg_nxt   = neg_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    case (state_r)
      D_IDLE: begin
        if (req.start) begin
          neg_nxt   = req.dividend[SUM_BITS-1];
          quo_nxt   = req.dividend[SUM_BITS-1] ? SUM_BITS'(-req.dividend)
                                               : SUM_BITS'(req.dividend);
          rem_nxt   = '0;
          dvs_nxt   = req.divisor;
          cnt_nxt   = '0;
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        rem_nxt = ge ? diff[PERIOD_BITS-1:0] : rem_sh[PERIOD_BITS-1:0];
        quo_nxt = {quo_r[SUM_BITS-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = D_FIX;
        end
      end
      D_FIX: begin
        // truncation toward zero: sign goes back on the magnitude
        quo_nxt   = neg_r ? (~quo_r + 1'b1) : quo_r;
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = $signed(quo_r);

endmodule

`default_nettype wire

### rtl/wilder_smoothing_average.sv
`timescale 1ns / 1ps
`default_nettype none

// Wilder smoothing average over signed Q16.16 samples.
// in_chan carries one request per sample (sample, restart); restart opens a new
// series. out_chan carries at most one result per sample (average, is_seed).
// cfg_chan writes the 16-bit period (zero acts as one); write it only while idle.
// The first period samples of a series are summed; the last of them gives the
// saturated plain mean with is_seed set. Every later sample gives
// (prev*(period-1)+x)/period, truncated toward zero.
// One sample is in work at a time and in_chan is not ready meanwhile.
// A warm-up sample without a result goes from S_PREP straight back to idle.
// A seed or a smoothing result passes these steps: setup (the multiply on the
// smoothing path), an add on the smoothing path only, a hand-off through the
// request register, the bit-serial divider shared by both, a sign fix, a
// capture into the result register and the result in the output register.
// in_chan is ready again in the same cycle that the result appears.
// The result sits in an output register; a new sample is taken while it waits,
// and a stalled receiver holds the next result back in the block until taken.
// Reset (rst_n low, synchronous) sets period to 14 and clears sum, count,
// previous average and seed state; no result is pending after reset.
module wilder_smoothing_average (
  input  logic        clk,
  input  logic        rst_n,
  wsa_in_if.sink      in_chan,
  wsa_out_if.source   out_chan,
  wsa_cfg_if.sink     cfg_chan
);
  import wsa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_ACC  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [PERIOD_BITS-1:0]         period_r;
  logic signed [SUM_BITS-1:0]     sum_r, sum_nxt;
  logic [PERIOD_BITS-1:0]         cnt_r, cnt_nxt;
  logic signed [SAMPLE_BITS-1:0]  prev_r, prev_nxt;
  logic                           seeded_r, seeded_nxt;
  logic signed [SAMPLE_BITS-1:0]  x_r, x_nxt;
  logic                           restart_r, restart_nxt;
  logic                           seed_r, seed_nxt;
  logic signed [SUM_BITS-1:0]     prod_r, prod_nxt;
  logic signed [SAMPLE_BITS-1:0]  res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  out_avg_r, out_avg_nxt;
  logic                           out_seed_r, out_seed_nxt;
  div_req_t                       req_r, req_nxt;
  div_rsp_t                       rsp;

  logic [PERIOD_BITS-1:0]         p_eff;
  logic [PERIOD_BITS-1:0]         pm1;
  logic signed [SUM_BITS-1:0]     x_ext;
  logic signed [SUM_BITS-1:0]     sum_base;
  logic [PERIOD_BITS-1:0]         cnt_inc;
  logic                           seeded_eff;
  logic                           q_in_range;
  logic signed [SAMPLE_BITS-1:0]  q_sat;
  logic                           out_free;
  logic signed [SAMPLE_BITS+PERIOD_BITS:0] mul_full;

  assign p_eff      = (period_r == '0) ? PERIOD_BITS'(1) : period_r;
  assign pm1        = p_eff - 1'b1;
  assign x_ext      = SUM_BITS'(x_r);
  assign sum_base   = restart_r ? '0 : sum_r;
  assign cnt_inc    = (restart_r ? '0 : cnt_r) + 1'b1;
  assign seeded_eff = seeded_r & ~restart_r;
  assign mul_full   = prev_r * $signed({1'b0, pm1});
  assign out_free   = ~out_valid_r | out_chan.ready;

  // saturate the quotient to the sample range
  assign q_in_range = (&rsp.quotient[SUM_BITS-1:SAMPLE_BITS-1]) |
                      ~(|rsp.quotient[SUM_BITS-1:SAMPLE_BITS-1]);
  always_comb begin
    if (q_in_range) begin
      q_sat = rsp.quotient[SAMPLE_BITS-1:0];
    end else if (rsp.quotient[SUM_BITS-1]) begin
      q_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      q_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    seeded_nxt    = seeded_r;
    x_nxt         = x_r;
    restart_nxt   = restart_r;
    seed_nxt      = seed_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_avg_nxt   = out_avg_r;
    out_seed_nxt  = out_seed_r;
    req_nxt       = req_r;
    req_nxt.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          x_nxt       = in_chan.sample;
          restart_nxt = in_chan.restart;
          state_nxt   = S_PREP;
        end
      end
      S_PREP: begin
        seeded_nxt = seeded_eff;
        if (!seeded_eff) begin
          sum_nxt = sum_base + x_ext;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= p_eff) begin
            req_nxt.start    = 1'b1;
            req_nxt.dividend = sum_base + x_ext;
            req_nxt.divisor  = p_eff;
            seed_nxt         = 1'b1;
            state_nxt        = S_DIV;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          prod_nxt  = SUM_BITS'(mul_full);
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        req_nxt.start    = 1'b1;
        req_nxt.dividend = prod_r + x_ext;
        req_nxt.divisor  = p_eff;
        seed_nxt         = 1'b0;
        state_nxt        = S_DIV;
      end
      S_DIV: begin
        if (rsp.done) begin
          res_nxt   = q_sat;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = res_r;
          out_seed_nxt  = seed_r;
          prev_nxt      = res_r;
          if (seed_r) begin
            seeded_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      prev_r      <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      req_r.start <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_chan.valid) begin
        period_r <= cfg_chan.data;
      end
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      req_r.start <= req_nxt.start;
    end
  end

  always_ff @(posedge clk) begin
    x_r            <= x_nxt;
    restart_r      <= restart_nxt;
    seed_r         <= seed_nxt;
    prod_r         <= prod_nxt;
    res_r          <= res_nxt;
    out_avg_r      <= out_avg_nxt;
    out_seed_r     <= out_seed_nxt;
    req_r.dividend <= req_nxt.dividend;
    req_r.divisor  <= req_nxt.divisor;
  end

  wsa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .rsp   (rsp)
  );

  assign in_chan.ready    = (state_r == S_IDLE);
  assign cfg_chan.ready   = 1'b1;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.average = out_avg_r;
  assign out_chan.is_seed = out_seed_r;

endmodule

`default_nettype wire

### sim/wsa_average_checker.sv
`timescale 1ns / 1ps

module wsa_average_checker
  import wsa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  wsa_in_if    in_mon,
  wsa_out_if   out_mon,
  wsa_cfg_if   cfg_mon,
  output int   fail_count,
  output int   waiting
);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic                          is_seed;
  } average_t;

  average_t expected_averages[$];

  logic [PERIOD_BITS-1:0]        period;
  longint                        warmup_sum;
  logic [PERIOD_BITS-1:0]        sample_count;
  logic signed [SAMPLE_BITS-1:0] prev_average;
  logic                          seeded;

  function automatic logic signed [SAMPLE_BITS-1:0] clamp_average(longint v);
    longint hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    longint lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return SAMPLE_BITS'(v);
  endfunction

  // advance the smoothing state by one request, queue the average it yields
  function automatic void smooth_sample(logic signed [SAMPLE_BITS-1:0] x_code, logic restart);
    longint                        x;
    longint                        divisor;
    longint                        count;
    longint                        prev;
    logic signed [SAMPLE_BITS-1:0] avg;
    logic                          emit;
    x = x_code;
    divisor = period;
    if (divisor == 0) divisor = 1;
    emit = 1'b0;
    if (restart) begin
      warmup_sum   = 0;
      sample_count = '0;
      seeded       = 1'b0;
    end
    if (!seeded) begin
      warmup_sum   += x;
      sample_count += 1'b1;
      count = sample_count;
      // seed as soon as the count catches up with the period in force now
      if (count >= divisor) begin
        avg    = clamp_average(warmup_sum / divisor);
        seeded = 1'b1;
        emit   = 1'b1;
        expected_averages.push_back('{avg, 1'b1});
      end
    end else begin
      prev = prev_average;
      avg  = clamp_average((prev * (divisor - 1) + x) / divisor);
      emit = 1'b1;
      expected_averages.push_back('{avg, 1'b0});
    end
    if (emit) prev_average = avg;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    average_t want;
    if (!rst_n) begin
      period       = PERIOD_RESET;
      warmup_sum   = 0;
      sample_count = '0;
      prev_average = '0;
      seeded       = 1'b0;
      expected_averages.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_averages.size() == 0) begin
          $error("average: expected none, actual %0d", out_mon.average);
          fail_count++;
        end else begin
          want = expected_averages.pop_front();
          if (out_mon.average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, out_mon.average);
            fail_count++;
          end
          if (out_mon.is_seed !== want.is_seed) begin
            $error("is_seed: expected %0b, actual %0b", want.is_seed, out_mon.is_seed);
            fail_count++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) period = cfg_mon.data;
      if (in_mon.valid && in_mon.ready) smooth_sample(in_mon.sample, in_mon.restart);
    end
    waiting <= expected_averages.size();
  end

endmodule

### sim/tb_wilder_smoothing_average.sv
`timescale 1ns / 1ps

module tb_wilder_smoothing_average;
  import wsa_pkg::*;

  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int RANDOM_SAMPLES = 850;

  localparam logic signed [SAMPLE_BITS-1:0] MAX_CODE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] MIN_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } sample_req_t;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          waiting;
  int          cycle_count;
  int          burst_left;
  sample_req_t sample_queue[$];

  wsa_in_if  in_if ();
  wsa_out_if out_if ();
  wsa_cfg_if cfg_if ();

  wilder_smoothing_average i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  wsa_average_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_wilder_smoothing_average: FAIL");
      $finish;
    end
  end

  // result side: stretches of steady, random, sparse and held-off ready
  initial begin
    rx_mode_t mode;
    int       run;
    int       phase;
    out_if.ready <= 1'b0;
    mode  = RX_ALWAYS;
    run   = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        run  = $urandom_range(20, 300);
      end
      run--;
      phase++;
      case (mode)
        RX_ALWAYS: out_if.ready <= 1'b1;
        RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_if.ready <= (phase % 5 == 0);
        RX_HOLD:   out_if.ready <= 1'b0;
      endcase
    end
  end

  task automatic queue_sample(logic signed [SAMPLE_BITS-1:0] s, logic r);
    sample_queue.push_back('{s, r});
  endtask

  // send queued requests in bursts with random gaps, valid stays up inside a burst
  task automatic send_queued();
    int          gap;
    sample_req_t req;
    while (sample_queue.size() > 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      req = sample_queue.pop_front();
      in_if.valid   <= 1'b1;
      in_if.sample  <= req.sample;
      in_if.restart <= req.restart;
      do @(posedge clk); while (!in_if.ready);
      burst_left--;
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic write_period(logic [PERIOD_BITS-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // warm-up requests give no result, so allow the block to finish after the last one
  task automatic wait_idle();
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return MAX_CODE;
      1:       return MIN_CODE;
      2:       return $urandom_range(0, 200) - 100;
      3, 4:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int                     sent;
    int                     batch;
    logic [PERIOD_BITS-1:0] next_period;
    logic                   open_series;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.sample   <= '0;
    in_if.restart  <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.data    <= '0;
    burst_left     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // warm-up under the reset period, then the period drops below the count
    queue_sample(MAX_CODE, 1'b1);
    repeat (5) queue_sample(MAX_CODE, 1'b0);
    send_queued();
    wait_idle();
    write_period(2);
    queue_sample(MAX_CODE, 1'b0);
    send_queued();

    // period one: every request averages to itself
    wait_idle();
    write_period(1);
    queue_sample(MIN_CODE, 1'b1);
    queue_sample(MAX_CODE, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(-1, 1'b0);
    send_queued();

    // period zero acts as one, restart on a seeded series
    wait_idle();
    write_period(0);
    queue_sample(1, 1'b0);
    queue_sample(-1, 1'b1);
    send_queued();

    // negative mean truncates toward zero, then smoothing at the extremes
    wait_idle();
    write_period(3);
    queue_sample(-5, 1'b1);
    queue_sample(-1, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(MIN_CODE, 1'b0);
    queue_sample(MAX_CODE, 1'b0);
    send_queued();

    // widest period after seeding, then a negative warm-up cut short
    wait_idle();
    write_period({PERIOD_BITS{1'b1}});
    queue_sample(MAX_CODE, 1'b0);
    queue_sample(MIN_CODE, 1'b0);
    repeat (3) queue_sample(MIN_CODE, 1'b1);
    send_queued();
    wait_idle();
    write_period(1);
    queue_sample(MIN_CODE, 1'b0);
    send_queued();

    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      case ($urandom_range(0, 19))
        0:       next_period = '0;
        1:       next_period = {PERIOD_BITS{1'b1}};
        2, 3:    next_period = PERIOD_BITS'($urandom_range(9, 40));
        default: next_period = PERIOD_BITS'($urandom_range(1, 8));
      endcase
      // most batches open a fresh series, the rest carry the old one across the change
      open_series = ($urandom_range(0, 3) != 0);
      batch = $urandom_range(10, 60);
      wait_idle();
      write_period(next_period);
      for (int i = 0; i < batch; i++) begin
        queue_sample(pick_sample(), (i == 0 && open_series) || $urandom_range(0, 24) == 0);
      end
      send_queued();
      sent += batch;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_wilder_smoothing_average: PASS");
    end else begin
      $display("tb_wilder_smoothing_average: FAIL");
    end
    $finish;
  end

endmodule
